// ===== design/tfa_pkg.sv =====
// Shared types, tag codes and sizes for the tagged FIFO frame assembler.
// Used by the front, queue, back end, top level and testbench; depends on nothing else.

package tfa_pkg;

    // Field widths.
    localparam int TAG_W    = 5;
    localparam int CNT_W    = 2;
    localparam int WORD_W   = 16;
    localparam int TS_W     = 32;
    localparam int PERIOD_W = 16;
    localparam int KIND_W   = 3;

    // Reset value of the batch period register.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd384;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Sensor tags as they come from the FIFO.
    localparam logic [TAG_W-1:0] TAG_GYRO  = 5'h01;
    localparam logic [TAG_W-1:0] TAG_ACCEL = 5'h02;
    localparam logic [TAG_W-1:0] TAG_TIME  = 5'h04;
    localparam logic [TAG_W-1:0] TAG_MAG   = 5'h0E;

    // Decoded word kinds carried through the queue.
    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_NONE  = 3'd0;
    localparam t_kind KIND_GYRO  = 3'd1;
    localparam t_kind KIND_ACCEL = 3'd2;
    localparam t_kind KIND_TIME  = 3'd3;
    localparam t_kind KIND_MAG   = 3'd4;

    // One input item as it arrives.
    typedef struct packed {
        logic [TAG_W-1:0]  sensor_tag;
        logic [CNT_W-1:0]  batch_count;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_c;
    } t_in_item;

    // One classified item, as queued for the back end.
    typedef struct packed {
        t_kind             kind;
        logic [CNT_W-1:0]  batch_count;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_c;
    } t_work;

    // One emitted record.
    typedef struct packed {
        logic [TS_W-1:0]          rec_timestamp;
        logic signed [WORD_W-1:0] rec_accel_x;
        logic signed [WORD_W-1:0] rec_accel_y;
        logic signed [WORD_W-1:0] rec_accel_z;
        logic signed [WORD_W-1:0] rec_gyro_x;
        logic signed [WORD_W-1:0] rec_gyro_y;
        logic signed [WORD_W-1:0] rec_gyro_z;
        logic signed [WORD_W-1:0] rec_mag_x;
        logic signed [WORD_W-1:0] rec_mag_y;
        logic signed [WORD_W-1:0] rec_mag_z;
    } t_out_rec;

    // Map a sensor tag to its word kind; unknown tags store nothing.
    function automatic t_kind tag_kind(input logic [TAG_W-1:0] tag);
        t_kind kind;
        case (tag)
            TAG_GYRO:  kind = KIND_GYRO;
            TAG_ACCEL: kind = KIND_ACCEL;
            TAG_TIME:  kind = KIND_TIME;
            TAG_MAG:   kind = KIND_MAG;
            default:   kind = KIND_NONE;
        endcase
        return kind;
    endfunction

endpackage

// ===== design/tfa_stream_if.sv =====
// Valid/ready stream interface used for the input and output channels.
// The payload type is a parameter; the design passes types from tfa_pkg.

interface tfa_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/tfa_front.sv =====
// Front end: accepts input transfers, decodes the tag and holds the item
// until the queue takes it. Depends on tfa_pkg and tfa_stream_if.

module tfa_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tfa_stream_if.sink           i_in,
    input  logic                 i_q_full,
    output logic                 o_push,
    output tfa_pkg::t_work       o_item
);

    logic            r_valid;
    logic            n_valid;
    tfa_pkg::t_work  r_item;
    logic            w_take;

    // The stage frees up whenever its item moves into the queue.
    assign o_push      = r_valid && !i_q_full;
    assign i_in.ready  = !r_valid || !i_q_full;
    assign w_take      = i_in.valid && i_in.ready;
    assign o_item      = r_item;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Decode the tag as the item is captured.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.kind        <= tfa_pkg::tag_kind(i_in.payload.sensor_tag);
            r_item.batch_count <= i_in.payload.batch_count;
            r_item.word_a      <= i_in.payload.word_a;
            r_item.word_b      <= i_in.payload.word_b;
            r_item.word_c      <= i_in.payload.word_c;
        end
    end

endmodule

// ===== design/tfa_queue.sv =====
// Small first-in first-out queue of decoded items between front and back.
// Depends on tfa_pkg for the item type.

module tfa_queue #(
    parameter int DEPTH = tfa_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tfa_pkg::t_work  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tfa_pkg::t_work  o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tfa_pkg::t_work    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Occupancy follows the push and pop of each cycle.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/tfa_back.sv =====
// Back end: holds the record state, emits the held record on a batch
// counter change, advances the timestamp and stores words by kind.
// Depends on tfa_pkg and tfa_stream_if.

module tfa_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tfa_pkg::PERIOD_W-1:0]      i_cfg_data,
    input  logic                              i_q_valid,
    input  tfa_pkg::t_work                    i_q_data,
    output logic                              o_pop,
    tfa_stream_if.source                      o_out
);

    localparam int W = tfa_pkg::WORD_W;

    logic [tfa_pkg::PERIOD_W-1:0] r_period;
    logic [tfa_pkg::CNT_W-1:0]    r_last;
    logic [tfa_pkg::TS_W-1:0]     r_ts;
    logic [W-1:0]                 r_acc [3];
    logic [W-1:0]                 r_gyr [3];
    logic [W-1:0]                 r_mag [3];
    logic                         r_out_valid;
    tfa_pkg::t_out_rec            r_out;

    logic [tfa_pkg::TS_W-1:0]     n_ts;
    logic [W-1:0]                 n_acc [3];
    logic [W-1:0]                 n_gyr [3];
    logic [W-1:0]                 n_mag [3];
    logic                         n_out_valid;

    logic                         w_change;
    logic [tfa_pkg::CNT_W-1:0]    w_diff;
    logic [tfa_pkg::PERIOD_W+1:0] w_step;
    logic [W-1:0]                 w_words [3];

    // A counter change needs the output register free or draining.
    assign w_change = (i_q_data.batch_count != r_last);
    assign o_pop    = i_q_valid && (!w_change || !r_out_valid || o_out.ready);
    assign w_diff   = i_q_data.batch_count - r_last;

    // Period times a two-bit difference, as two shifted terms.
    assign w_step = ({1'b0, r_period, 1'b0} & {(tfa_pkg::PERIOD_W+2){w_diff[1]}})
                  + ({2'b00, r_period} & {(tfa_pkg::PERIOD_W+2){w_diff[0]}});

    assign w_words[0] = i_q_data.word_a;
    assign w_words[1] = i_q_data.word_b;
    assign w_words[2] = i_q_data.word_c;

    // Next held state: clear and advance on a change, then store by kind.
    always_comb begin
        n_ts  = r_ts;
        n_acc = r_acc;
        n_gyr = r_gyr;
        n_mag = r_mag;
        if (w_change) begin
            n_ts = r_ts + {{(tfa_pkg::TS_W-tfa_pkg::PERIOD_W-2){1'b0}}, w_step};
            for (int i = 0; i < 3; i++) begin
                n_acc[i] = '0;
                n_gyr[i] = '0;
                n_mag[i] = '0;
            end
        end
        case (i_q_data.kind)
            tfa_pkg::KIND_GYRO:  n_gyr = w_words;
            tfa_pkg::KIND_ACCEL: n_acc = w_words;
            tfa_pkg::KIND_MAG:   n_mag = w_words;
            tfa_pkg::KIND_TIME:  n_ts  = {i_q_data.word_b, i_q_data.word_a};
            default:             n_ts  = n_ts;
        endcase
    end

    // Output register valid: set by an emitting pop, cleared by a transfer.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop && w_change) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= tfa_pkg::PERIOD_RESET;
            r_last      <= '0;
            r_ts        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= '0;
                r_gyr[i] <= '0;
                r_mag[i] <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_period <= i_cfg_data;
            end
            if (o_pop) begin
                r_last <= i_q_data.batch_count;
                r_ts   <= n_ts;
                r_acc  <= n_acc;
                r_gyr  <= n_gyr;
                r_mag  <= n_mag;
            end
        end
    end

    // Capture the held record as it stood before this item.
    always_ff @(posedge i_clk) begin
        if (o_pop && w_change) begin
            r_out.rec_timestamp <= r_ts;
            r_out.rec_accel_x   <= r_acc[0];
            r_out.rec_accel_y   <= r_acc[1];
            r_out.rec_accel_z   <= r_acc[2];
            r_out.rec_gyro_x    <= r_gyr[0];
            r_out.rec_gyro_y    <= r_gyr[1];
            r_out.rec_gyro_z    <= r_gyr[2];
            r_out.rec_mag_x     <= r_mag[0];
            r_out.rec_mag_y     <= r_mag[1];
            r_out.rec_mag_z     <= r_mag[2];
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

// ===== design/tagged_fifo_frame_assembler.sv =====
// Top level of the tagged FIFO frame assembler: front decode, queue, back end.
// Depends on tfa_pkg, tfa_stream_if, tfa_front, tfa_queue and tfa_back.
//
//   Channel   Direction  Payload               Handshake
//   i_in      in         tfa_pkg::t_in_item    valid/ready
//   o_out     out        tfa_pkg::t_out_rec    valid/ready
//   i_cfg_*   in         batch period, 16 bit  write enable, no wait
//
// One item is taken per cycle while the queue has room; the back end retires one
// queued item per cycle unless the output stalls; a record is registered as its
// item pops. Reset is synchronous and active low and clears the record state.
// A stalled output holds the back end only on items that emit a record; the
// queue of QUEUE_DEPTH entries then absorbs input until it fills.

module tagged_fifo_frame_assembler #(
    parameter int QUEUE_DEPTH = tfa_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tfa_stream_if.sink                    i_in,
    tfa_stream_if.source                  o_out,
    input  logic                          i_cfg_we,
    input  logic [tfa_pkg::PERIOD_W-1:0]  i_cfg_data
);

    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_q_valid;
    tfa_pkg::t_work  w_front_item;
    tfa_pkg::t_work  w_head_item;

    // Decode stage.
    tfa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_item   (w_front_item)
    );

    // Decoupling queue.
    tfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_head_item)
    );

    // Record state and output register.
    tfa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (w_q_valid),
        .i_q_data   (w_head_item),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

endmodule

// ===== dv/tb_tagged_fifo_frame_assembler.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tagged_fifo_frame_assembler: a directed table, then random
// sensor batches under several idling modes. Depends on tfa_pkg, tfa_stream_if and the RTL.

module tb_tagged_fifo_frame_assembler;

    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 12;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 244;
    localparam int DIR_ROWS = 22;
    localparam int REC_FIELDS = 10;
    localparam int MAX_GAP = 60;

    // One row of the directed table; typed rows carry the record they must produce.
    typedef struct {
        tfa_pkg::t_in_item word;
        bit                typed;
        tfa_pkg::t_out_rec rec;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [tfa_pkg::PERIOD_W-1:0] i_cfg_data;

    tfa_stream_if #(.t_payload(tfa_pkg::t_in_item)) in_if ();
    tfa_stream_if #(.t_payload(tfa_pkg::t_out_rec)) out_if ();

    tagged_fifo_frame_assembler u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor state, a copy of what the block holds.
    logic [tfa_pkg::PERIOD_W-1:0] pred_period = tfa_pkg::PERIOD_RESET;
    logic [tfa_pkg::CNT_W-1:0]    held_count = '0;
    logic [tfa_pkg::TS_W-1:0]     held_ts = '0;
    logic [tfa_pkg::WORD_W-1:0]   held_accel [3] = '{default: '0};
    logic [tfa_pkg::WORD_W-1:0]   held_gyro [3] = '{default: '0};
    logic [tfa_pkg::WORD_W-1:0]   held_mag [3] = '{default: '0};

    tfa_pkg::t_out_rec pending_records [$];
    tfa_pkg::t_out_rec known_records [int];
    int words_sent = 0;
    int words_taken = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    logic [tfa_pkg::CNT_W-1:0] drv_count = '0;

    string rec_field [REC_FIELDS] = '{"rec_timestamp", "rec_accel_x", "rec_accel_y",
        "rec_accel_z", "rec_gyro_x", "rec_gyro_y", "rec_gyro_z", "rec_mag_x", "rec_mag_y",
        "rec_mag_z"};

    // Directed rows: field extremes, every tag, unknown tags, counter jumps and
    // timestamp wraparound. Typed records are the ones readable straight off the data.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{'{tfa_pkg::TAG_GYRO,  2'd0, 16'h7FFF, 16'h8000, 16'hFFFF}, 1'b0, '0},
        '{'{tfa_pkg::TAG_ACCEL, 2'd0, 16'h0001, 16'hFFFF, 16'h8000}, 1'b0, '0},
        '{'{tfa_pkg::TAG_MAG,   2'd0, 16'h8000, 16'h7FFF, 16'h0000}, 1'b0, '0},
        '{'{tfa_pkg::TAG_TIME,  2'd0, 16'hFFF0, 16'hFFFF, 16'h1234}, 1'b0, '0},
        '{'{5'h00,     2'd1, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{32'hFFFF_FFF0, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF,
            16'h8000, 16'h7FFF, 16'h0000}},
        '{'{5'h1F,     2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{tfa_pkg::TAG_GYRO,  2'd3, 16'h0001, 16'h0002, 16'h0003}, 1'b1,
          '{32'h0000_0170, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}},
        '{'{tfa_pkg::TAG_TIME,  2'd3, 16'h0000, 16'h0000, 16'hFFFF}, 1'b0, '0},
        '{'{tfa_pkg::TAG_ACCEL, 2'd2, 16'hFFFF, 16'h0000, 16'h7FFF}, 1'b1,
          '{32'h0000_0000, 16'h0, 16'h0, 16'h0, 16'h1, 16'h2, 16'h3, 16'h0, 16'h0, 16'h0}},
        '{'{tfa_pkg::TAG_MAG,   2'd2, 16'h0000, 16'hFFFF, 16'h8000}, 1'b0, '0},
        '{'{tfa_pkg::TAG_TIME,  2'd1, 16'h1234, 16'h5678, 16'hFFFF}, 1'b0, '0},
        '{'{5'h1F,     2'd0, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{32'h5678_1234, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}},
        '{'{5'h03,     2'd0, 16'h1111, 16'h2222, 16'h3333}, 1'b0, '0},
        '{'{5'h0F,     2'd0, 16'h4444, 16'h5555, 16'h6666}, 1'b0, '0},
        '{'{5'h10,     2'd0, 16'h7777, 16'h8888, 16'h9999}, 1'b0, '0},
        '{'{tfa_pkg::TAG_GYRO,  2'd1, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{tfa_pkg::TAG_GYRO,  2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{tfa_pkg::TAG_ACCEL, 2'd2, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
        '{'{tfa_pkg::TAG_MAG,   2'd3, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '0},
        '{'{tfa_pkg::TAG_TIME,  2'd0, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b0, '0},
        '{'{5'h00,     2'd1, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}},
        '{'{5'h00,     2'd1, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, '0}
    };

    // Predict the block's response to one accepted word; updates the held record.
    task automatic assemble_word(input tfa_pkg::t_in_item w, output bit emitted,
                                 output tfa_pkg::t_out_rec rec);
        logic [tfa_pkg::CNT_W-1:0] diff;
        emitted = 1'b0;
        rec = '0;
        if (w.batch_count != held_count) begin
            rec.rec_timestamp = held_ts;
            rec.rec_accel_x = held_accel[0];
            rec.rec_accel_y = held_accel[1];
            rec.rec_accel_z = held_accel[2];
            rec.rec_gyro_x = held_gyro[0];
            rec.rec_gyro_y = held_gyro[1];
            rec.rec_gyro_z = held_gyro[2];
            rec.rec_mag_x = held_mag[0];
            rec.rec_mag_y = held_mag[1];
            rec.rec_mag_z = held_mag[2];
            emitted = 1'b1;
            held_accel = '{default: '0};
            held_gyro = '{default: '0};
            held_mag = '{default: '0};
            diff = w.batch_count - held_count;
            held_ts = held_ts + tfa_pkg::TS_W'(pred_period) * tfa_pkg::TS_W'(diff);
            held_count = w.batch_count;
        end
        case (w.sensor_tag)
            tfa_pkg::TAG_GYRO:  held_gyro = '{w.word_a, w.word_b, w.word_c};
            tfa_pkg::TAG_ACCEL: held_accel = '{w.word_a, w.word_b, w.word_c};
            tfa_pkg::TAG_MAG:   held_mag = '{w.word_a, w.word_b, w.word_c};
            tfa_pkg::TAG_TIME:  held_ts = {w.word_b, w.word_a};
            default:   ;
        endcase
    endtask

    // Field-by-field comparison of one record transfer against its expectation.
    task automatic compare_record(input tfa_pkg::t_out_rec want,
                                  input tfa_pkg::t_out_rec got);
        logic [$bits(tfa_pkg::t_out_rec)-1:0] wb;
        logic [$bits(tfa_pkg::t_out_rec)-1:0] gb;
        logic [tfa_pkg::TS_W-1:0] wf;
        logic [tfa_pkg::TS_W-1:0] gf;
        wb = want;
        gb = got;
        for (int i = 0; i < REC_FIELDS; i++) begin
            if (i == 0) begin
                wf = wb[16*(REC_FIELDS-1) +: tfa_pkg::TS_W];
                gf = gb[16*(REC_FIELDS-1) +: tfa_pkg::TS_W];
            end else begin
                wf = tfa_pkg::TS_W'(wb[16*(REC_FIELDS-1-i) +: tfa_pkg::WORD_W]);
                gf = tfa_pkg::TS_W'(gb[16*(REC_FIELDS-1-i) +: tfa_pkg::WORD_W]);
            end
            if (wf !== gf) begin
                $error("%s: expected %h, got %h", rec_field[i], wf, gf);
                mismatches++;
            end
        end
    endtask

    // Observe transfers and register writes at each clock edge.
    always @(posedge i_clk) begin
        bit emitted;
        tfa_pkg::t_out_rec rec;
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (pending_records.size() == 0) begin
                    $error("record transfer with no expectation pending");
                    mismatches++;
                end else begin
                    compare_record(pending_records.pop_front(), out_if.payload);
                end
            end
            if (in_if.valid && in_if.ready) begin
                assemble_word(in_if.payload, emitted, rec);
                if (known_records.exists(words_taken)) begin
                    pending_records.push_back(known_records[words_taken]);
                end else if (emitted) begin
                    pending_records.push_back(rec);
                end
                words_taken++;
            end
            if (i_cfg_we) begin
                pred_period = i_cfg_data;
            end
        end
    end

    // Receiver stalls at the rate of the current idling mode.
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hang guard.
    always @(posedge i_clk) begin
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_tagged_fifo_frame_assembler NOT OK");
            $finish;
        end
    end

    // Offer one word after a random gap and hold it until the transfer happens.
    task automatic send_word(input tfa_pkg::t_in_item w);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.payload <= w;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        words_sent++;
        drv_count = w.batch_count;
    endtask

    // Wait until every expected record has arrived and queued words have retired.
    task automatic drain_block();
        @(posedge i_clk);
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [tfa_pkg::PERIOD_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random stream: mostly well-formed batches of sensor words, some noise words.
    task automatic send_random_words(input int quota);
        int done;
        int len;
        int pick;
        logic [tfa_pkg::CNT_W-1:0] next_count;
        tfa_pkg::t_in_item w;
        done = 0;
        while (done < quota) begin
            if ($urandom_range(99) < 15) begin
                w.sensor_tag = tfa_pkg::TAG_W'($urandom);
                w.batch_count = tfa_pkg::CNT_W'($urandom);
                w.word_a = tfa_pkg::WORD_W'($urandom);
                w.word_b = tfa_pkg::WORD_W'($urandom);
                w.word_c = tfa_pkg::WORD_W'($urandom);
                if (w.sensor_tag inside {tfa_pkg::TAG_GYRO, tfa_pkg::TAG_ACCEL,
                                         tfa_pkg::TAG_TIME, tfa_pkg::TAG_MAG} ||
                    w.batch_count != drv_count) begin
                    done++;
                end
                send_word(w);
            end else begin
                next_count = drv_count +
                    tfa_pkg::CNT_W'(($urandom_range(7) == 0) ? $urandom_range(2, 3) : 1);
                len = $urandom_range(1, 4);
                for (int j = 0; j < len; j++) begin
                    pick = $urandom_range(9);
                    w.sensor_tag = (pick < 3) ? tfa_pkg::TAG_GYRO :
                                   (pick < 6) ? tfa_pkg::TAG_ACCEL :
                                   (pick < 9) ? tfa_pkg::TAG_MAG : tfa_pkg::TAG_TIME;
                    w.batch_count = next_count;
                    w.word_a = tfa_pkg::WORD_W'($urandom);
                    w.word_b = tfa_pkg::WORD_W'($urandom);
                    w.word_c = tfa_pkg::WORD_W'($urandom);
                    send_word(w);
                    done++;
                end
            end
        end
    endtask

    // Main sequence: reset, directed table, then random phases with new periods.
    initial begin
        logic [tfa_pkg::PERIOD_W-1:0] period;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        out_if.ready = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].typed) begin
                known_records[words_sent] = dir_rows[r].rec;
            end
            send_word(dir_rows[r].word);
        end

        for (int p = 0; p < PHASES; p++) begin
            in_if.valid <= 1'b0;
            drain_block();
            case (p % 4)
                0: period = 16'd1;
                1: period = 16'hFFFF;
                2: period = 16'd0;
                default: period = tfa_pkg::PERIOD_W'($urandom_range(2, 65534));
            endcase
            write_period(period);
            // Idling modes: none, sender idle, receiver stalled, both lightly.
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 84;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 84;
                end
                default: begin
                    send_idle_pct = 8;
                    stall_pct = 8;
                end
            endcase
            send_random_words(WORDS_PER_PHASE);
        end
        in_if.valid <= 1'b0;
        drain_block();

        if (mismatches == 0) begin
            $display("tb_tagged_fifo_frame_assembler OK");
        end else begin
            $display("tb_tagged_fifo_frame_assembler NOT OK");
        end
        $finish;
    end

endmodule

// ===== tagged_fifo_frame_assembler.f =====
design/tfa_pkg.sv
design/tfa_stream_if.sv
design/tfa_front.sv
design/tfa_queue.sv
design/tfa_back.sv
design/tagged_fifo_frame_assembler.sv
dv/tb_tagged_fifo_frame_assembler.sv
